[src/assert_macros.svh]
// Assertion macros shared by the RTL of the LRU page stack.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: label");

// Antecedent on one edge forces the consequent on the next.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

[src/lrup_pkg.sv]
// Package for the LRU page stack: sizes, widths and the cell link type.
// No dependencies; imported by every module of the block.
package lrup_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int PAGE_BITS  = 16;
    localparam int FILL_W     = $clog2(MAX_FRAMES + 1);
    localparam int CFG_W      = 5;
    localparam int FAULT_W    = 32;

    localparam logic [FAULT_W-1:0] FAULT_MAX    = '1;
    localparam logic [CFG_W-1:0]   FRAMES_RESET = CFG_W'(3);

    typedef logic [PAGE_BITS-1:0] t_page;
    typedef logic [FILL_W-1:0]    t_fill;
    typedef logic [FAULT_W-1:0]   t_fault;

    // Passed from one cell to the next older one.
    typedef struct packed {
        t_page page;   // entry handed down on a shift
        logic  found;  // match seen in this or a more recent cell
    } t_link;

endpackage

[src/lrup_cell.sv]
// One entry of the LRU stack: holds a page, compares it and shifts it on.
// Depends on lrup_pkg.
module lrup_cell (
    input  logic           i_clk,
    input  logic           i_load,
    input  logic           i_valid,
    input  lrup_pkg::t_page i_page,
    input  lrup_pkg::t_link i_link,
    output lrup_pkg::t_link o_link
);
    import lrup_pkg::*;

    t_page r_entry;
    logic  w_match;

    assign w_match      = i_valid && (r_entry == i_page);
    assign o_link.found = i_link.found | w_match;
    assign o_link.page  = r_entry;

    // shift while no match above; the matching cell is overwritten too
    always_ff @(posedge i_clk) begin
        if (i_load && !i_link.found) begin
            r_entry <= i_link.page;
        end
    end

endmodule

[src/lrup_stack.sv]
// Row of LRU cells, most recent in cell 0, with the fill count.
// Depends on lrup_pkg, lrup_cell and assert_macros.svh.
`include "assert_macros.svh"
module lrup_stack (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  logic            i_clear,
    input  lrup_pkg::t_page i_page,
    input  lrup_pkg::t_fill i_frames,
    output logic            o_hit
);
    import lrup_pkg::*;

    t_fill r_fill;
    t_fill n_fill;
    t_link w_link [MAX_FRAMES+1];
    logic  [MAX_FRAMES-1:0] w_valid;

    assign w_link[0].page  = i_page;
    assign w_link[0].found = 1'b0;
    assign o_hit           = w_link[MAX_FRAMES].found;

    for (genvar k = 0; k < MAX_FRAMES; k++) begin : g_cell
        assign w_valid[k] = (FILL_W'(k) < r_fill);
        lrup_cell u_cell (
            .i_clk   (i_clk),
            .i_load  (i_load),
            .i_valid (w_valid[k]),
            .i_page  (i_page),
            .i_link  (w_link[k]),
            .o_link  (w_link[k+1])
        );
    end

    // a miss past the frame limit drops the oldest entries by trimming the fill
    always_comb begin
        n_fill = r_fill;
        if (i_load) begin
            if (i_clear) begin
                n_fill = '0;
            end else if (!o_hit) begin
                n_fill = (r_fill >= i_frames) ? i_frames : r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    `ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n, r_fill <= FILL_W'(MAX_FRAMES))
    `ASSERT_NEXT(a_fill_nonzero, i_clk, i_rst_n, i_load && !i_clear, r_fill != '0)

endmodule

[src/lru_page_replacement.sv]
// LRU page stack, top level. The result is strobed in the cycle after start.
// Throughput: one reference per cycle; busy stays low, the cell row searches
// combinationally and shifts as a reference is taken. Synchronous active-low
// reset empties the stack, clears the fault count and sets the frame count to 3.
// Results cannot be stalled by the receiver.
// Depends on lrup_pkg, lrup_stack and assert_macros.svh.
`include "assert_macros.svh"
module lru_page_replacement (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [lrup_pkg::PAGE_BITS-1:0] i_page,
    input  logic                       i_last_reference,
    input  logic                       i_cfg_we,
    input  logic [lrup_pkg::CFG_W-1:0] i_cfg_data,
    output logic                       o_strobe,
    output logic                       o_hit,
    output logic [lrup_pkg::FAULT_W-1:0] o_fault_count
);
    import lrup_pkg::*;

    logic [CFG_W-1:0] r_frames;
    t_fill            w_frames;
    t_fault           r_fault;
    t_fault           n_fault_res;
    logic             w_accept;
    logic             w_hit;
    logic             r_strobe;
    logic             r_hit;
    t_fault           r_fault_out;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // zero acts as one frame, anything past the depth as the full depth
    always_comb begin
        if (r_frames == '0) begin
            w_frames = FILL_W'(1);
        end else if (FILL_W'(r_frames) > FILL_W'(MAX_FRAMES)) begin
            w_frames = FILL_W'(MAX_FRAMES);
        end else begin
            w_frames = FILL_W'(r_frames);
        end
    end

    lrup_stack u_stack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept),
        .i_clear  (i_last_reference),
        .i_page   (i_page),
        .i_frames (w_frames),
        .o_hit    (w_hit)
    );

    assign n_fault_res = (!w_hit && r_fault != FAULT_MAX) ? r_fault + 1'b1 : r_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= FRAMES_RESET;
            r_fault  <= '0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frames <= i_cfg_data;
            end
            r_strobe <= w_accept;
            if (w_accept) begin
                r_fault <= i_last_reference ? '0 : n_fault_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit       <= w_hit;
            r_fault_out <= n_fault_res;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_hit         = r_hit;
    assign o_fault_count = r_fault_out;

    `ASSERT_NEXT(a_strobe_follows, i_clk, i_rst_n, w_accept, o_strobe)
    `ASSERT_NEXT(a_no_spurious, i_clk, i_rst_n, !w_accept, !o_strobe)
    `ASSERT_NEXT(a_hit_keeps_count, i_clk, i_rst_n, w_accept && w_hit, o_fault_count == $past(r_fault))

endmodule
